// ===== rtl/utf8_to_cesu8_transcoder_core_assert.svh =====
// Assertion macros shared by the transcoder RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef UTF8_TO_CESU8_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_CESU8_TRANSCODER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define U2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define U2C_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define U2C_ASSERT(lbl, prop, msg)
`define U2C_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/u2c_pkg.sv =====
// Shared types, constants and byte encoders of the UTF-8 to CESU-8 transcoder.
// No dependencies.
package u2c_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;
  localparam logic [9:0]  LO_MASK   = 10'h3FF;

  // One decoded input word: replacements before, an optional code point,
  // replacements after.
  typedef struct packed {
    logic [1:0]  npre;
    logic        has_code;
    logic [20:0] code;
    logic [1:0]  npost;
  } u2c_cmd_t;

  typedef struct packed {
    logic     valid;
    u2c_cmd_t cmd;
  } u2c_beat_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_PRE,
    PH_CODE,
    PH_POST
  } u2c_phase_e;

  function automatic logic [2:0] code_len(input logic [20:0] cp);
    if (cp < 21'h80) begin
      return 3'd1;
    end else if (cp < 21'h800) begin
      return 3'd2;
    end else if (cp < SUPP_BASE) begin
      return 3'd3;
    end
    return 3'd6;
  endfunction

  function automatic logic [7:0] put3_byte(input logic [15:0] u, input logic [1:0] k);
    case (k)
      2'd0:    return 8'hE0 | {4'h0, u[15:12]};
      2'd1:    return 8'h80 | {2'b00, u[11:6]};
      default: return 8'h80 | {2'b00, u[5:0]};
    endcase
  endfunction

  // Byte idx of the CESU-8 form of cp.
  function automatic logic [7:0] code_byte(input logic [20:0] cp, input logic [2:0] idx);
    logic [19:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    v  = 20'(cp - SUPP_BASE);
    hi = HI_SURR + {6'h00, v[19:10]};
    lo = LO_SURR + {6'h00, v[9:0] & LO_MASK};
    if (cp < 21'h80) begin
      return cp[7:0];
    end else if (cp < 21'h800) begin
      return (idx == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      return put3_byte(cp[15:0], idx[1:0]);
    end else if (idx < 3'd3) begin
      return put3_byte(hi, idx[1:0]);
    end
    return put3_byte(lo, 2'(idx - 3'd3));
  endfunction

endpackage

// ===== rtl/u2c_chan_if.sv =====
// Valid/ready channel interfaces for the transcoder input and output streams.
// No dependencies.
interface u2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;
  modport source(output valid, output in_byte, output buffer_end, input ready);
  modport sink(input valid, input in_byte, input buffer_end, output ready);
endinterface

interface u2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source(output valid, output out_byte, output run_last, input ready);
  modport sink(input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/utf8_to_cesu8_transcoder_core.sv =====
// UTF-8 to CESU-8 transcoder, top level. Depends on u2c_pkg, u2c_chan_if,
// u2c_front, u2c_queue and u2c_back.
//
// Usage: push raw UTF-8 bytes into in_i, one word per handshake, with
// buffer_end set on the last byte of a buffer. CESU-8 bytes come out of out_o,
// one word per handshake; run_last marks the final byte caused by an input
// byte. A byte that only extends a pending sequence yields no output word.
// Supplementary code points leave as two 3-byte surrogate halves; malformed
// or truncated input leaves as EF BF BD per pending byte.
// The accepting edge writes the decoded command of an input byte into the
// queue; its first output byte is then loaded into the output register.
// Throughput: the byte sequencer emits one output word per cycle while the
// receiver takes them; an input byte causes 0 to 12 output words. Input is
// taken every cycle while the command queue has room.
// Reset clears the decoder state, the queue and the output register.
// When the receiver stalls, the output word holds; the queue fills and then
// in_i.ready drops.
module utf8_to_cesu8_transcoder_core #(
  parameter int unsigned QueueDepth = u2c_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2c_in_if.sink    in_i,
  u2c_out_if.source out_o
);
  import u2c_pkg::*;

  u2c_beat_t push;
  u2c_beat_t head;
  logic      full;
  logic      pop;

  // Decode and classify each accepted byte
  u2c_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_byte_i    (in_i.in_byte),
    .buffer_end_i (in_i.buffer_end),
    .in_ready_o   (in_i.ready),
    .full_i       (full),
    .push_o       (push)
  );

  // Hold decoded commands so the decoder runs ahead of a stalled output
  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Expand commands into output bytes
  u2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last)
  );

endmodule

// ===== rtl/u2c_front.sv =====
// Front end: UTF-8 decoder state, validity checks, command generation.
// Depends on u2c_pkg and the assertion macro header.
`include "utf8_to_cesu8_transcoder_core_assert.svh"
module u2c_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                buffer_end_i,
  output logic                in_ready_o,
  input  logic                full_i,
  output u2c_pkg::u2c_beat_t  push_o
);
  import u2c_pkg::*;

  logic [1:0]  pend_q, pend_d, pend_inc;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d, acc_ext;
  logic        cont_ok, taken, accept;
  u2c_cmd_t    cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    cmd      = '0;
    pend_d   = pend_q;
    len_d    = len_q;
    acc_d    = acc_q;
    taken    = 1'b0;
    acc_ext  = {acc_q[14:0], in_byte_i[5:0]};
    pend_inc = pend_q + 2'd1;
    cont_ok  = (in_byte_i[7:6] == 2'b10);
    // Reject overlongs, surrogates and values past U+10FFFF on the second byte
    if (pend_q == 2'd1) begin
      if (len_q == 3'd3) begin
        if (acc_q == 21'h0 && in_byte_i < 8'hA0) cont_ok = 1'b0;
        if (acc_q == 21'hD && in_byte_i >= 8'hA0) cont_ok = 1'b0;
      end else if (len_q == 3'd4) begin
        if (acc_q == 21'h0 && in_byte_i < 8'h90) cont_ok = 1'b0;
        if (acc_q == 21'h4 && in_byte_i >= 8'h90) cont_ok = 1'b0;
      end
    end
    if (pend_q != 2'd0) begin
      if (cont_ok) begin
        taken  = 1'b1;
        acc_d  = acc_ext;
        pend_d = pend_inc;
        if ({1'b0, pend_inc} >= len_q || pend_inc == 2'd0) begin
          cmd.has_code = 1'b1;
          cmd.code     = acc_ext;
          pend_d       = 2'd0;
          len_d        = 3'd0;
          acc_d        = '0;
        end
      end else begin
        // Flush the broken sequence, then restart on this byte
        cmd.npre = pend_q;
        pend_d   = 2'd0;
        len_d    = 3'd0;
        acc_d    = '0;
      end
    end
    if (!taken) begin
      if (in_byte_i < 8'h80) begin
        cmd.has_code = 1'b1;
        cmd.code     = {13'h0, in_byte_i};
      end else if (in_byte_i inside {[8'hC2:8'hDF]}) begin
        len_d  = 3'd2;
        pend_d = 2'd1;
        acc_d  = {16'h0, in_byte_i[4:0]};
      end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
        len_d  = 3'd3;
        pend_d = 2'd1;
        acc_d  = {17'h0, in_byte_i[3:0]};
      end else if (in_byte_i inside {[8'hF0:8'hF4]}) begin
        len_d  = 3'd4;
        pend_d = 2'd1;
        acc_d  = {18'h0, in_byte_i[2:0]};
      end else begin
        cmd.has_code = 1'b1;
        cmd.code     = REPL_CP;
      end
    end
    // Drop a truncated sequence at the end of the buffer
    if (buffer_end_i && pend_d != 2'd0) begin
      cmd.npost = pend_d;
      pend_d    = 2'd0;
      len_d     = 3'd0;
      acc_d     = '0;
    end
  end

  assign push_o.valid = accept && (cmd.npre != 2'd0 || cmd.has_code || cmd.npost != 2'd0);
  assign push_o.cmd   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      len_q  <= 3'd0;
      acc_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
    end
  end

  `U2C_ASSERT(a_front_pend_bound, pend_q != 2'd0 |-> ({1'b0, pend_q} < len_q && len_q >= 3'd2), "pending count out of range")

endmodule

// ===== rtl/u2c_queue.sv =====
// Short command queue between the decoder and the byte sequencer.
// Depends on u2c_pkg and the assertion macro header.
`include "utf8_to_cesu8_transcoder_core_assert.svh"
module u2c_queue #(
  parameter int unsigned Depth = u2c_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u2c_pkg::u2c_beat_t push_i,
  output logic               full_o,
  output u2c_pkg::u2c_beat_t head_o,
  input  logic               pop_i
);
  import u2c_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2c_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `U2C_ASSERT_NEVER(a_queue_overflow, push_i.valid && full_o, "push into full queue")
  `U2C_ASSERT_NEVER(a_queue_underflow, pop_i && cnt_q == '0, "pop from empty queue")

endmodule

// ===== rtl/u2c_back.sv =====
// Back end: expands queued commands into CESU-8 bytes, one per cycle while the
// output register is free, into a registered output word. Depends on u2c_pkg and the macro header.
`include "utf8_to_cesu8_transcoder_core_assert.svh"
module u2c_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u2c_pkg::u2c_beat_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o
);
  import u2c_pkg::*;

  u2c_phase_e  phase_q, phase_d, cur_ph, nxt_ph;
  logic [1:0]  unit_q, unit_d, unit_cnt;
  logic [2:0]  idx_q, idx_d, unit_len;
  logic        unit_end, phase_end, cmd_end, step, out_free;
  logic        valid_q, last_q;
  logic [7:0]  byte_q, byte_d;

  assign out_free = !valid_q || out_ready_i;
  assign step     = head_i.valid && out_free;

  // Decode where the sequencer stands within the head command
  always_comb begin
    if (phase_q != PH_START) begin
      cur_ph = phase_q;
    end else if (head_i.cmd.npre != 2'd0) begin
      cur_ph = PH_PRE;
    end else if (head_i.cmd.has_code) begin
      cur_ph = PH_CODE;
    end else begin
      cur_ph = PH_POST;
    end
    case (cur_ph)
      PH_PRE: begin
        nxt_ph = head_i.cmd.has_code ? PH_CODE :
                 (head_i.cmd.npost != 2'd0) ? PH_POST : PH_START;
      end
      PH_CODE: nxt_ph = (head_i.cmd.npost != 2'd0) ? PH_POST : PH_START;
      default: nxt_ph = PH_START;
    endcase
    unit_len  = (cur_ph == PH_CODE) ? code_len(head_i.cmd.code) : 3'd3;
    unit_cnt  = (cur_ph == PH_PRE) ? head_i.cmd.npre : head_i.cmd.npost;
    unit_end  = (idx_q == unit_len - 3'd1);
    phase_end = unit_end && (cur_ph == PH_CODE || unit_q == unit_cnt - 2'd1);
    cmd_end   = phase_end && (nxt_ph == PH_START);
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    unit_d  = unit_q;
    idx_d   = idx_q;
    if (step) begin
      if (phase_end) begin
        phase_d = nxt_ph;
        unit_d  = 2'd0;
        idx_d   = 3'd0;
      end else if (unit_end) begin
        phase_d = cur_ph;
        unit_d  = unit_q + 2'd1;
        idx_d   = 3'd0;
      end else begin
        phase_d = cur_ph;
        idx_d   = idx_q + 3'd1;
      end
    end
  end

  // Outputs
  always_comb begin
    byte_d = (cur_ph == PH_CODE) ? code_byte(head_i.cmd.code, idx_q) : code_byte(REPL_CP, idx_q);
    pop_o  = step && cmd_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      unit_q  <= 2'd0;
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      unit_q  <= unit_d;
      idx_q   <= idx_d;
      if (step) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= byte_d;
      last_q <= cmd_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;

  `U2C_ASSERT(a_back_head_held, phase_q != PH_START |-> head_i.valid, "command lost mid-expansion")

endmodule

// ===== dv/utf8_to_cesu8_transcoder_core_test.sv =====
// Self-checking testbench for utf8_to_cesu8_transcoder_core: directed byte table, then random
// UTF-8 traffic, with the CESU-8 output checked word by word against a behavioral decoder.
// Depends on u2c_pkg, u2c_chan_if and the transcoder RTL.
`timescale 1ns / 100ps

module utf8_to_cesu8_transcoder_core_test;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int unsigned RAND_WORDS  = 250;
  localparam int unsigned HOLD_AFTER  = 60;    // input words before the long output stall
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned TAIL_CYCLES = 16;

  // Replacement character U+FFFD as UTF-8/CESU-8 bytes, left-aligned in a 12-byte run.
  localparam logic [95:0] NO_BYTES = 96'h0;
  localparam logic [95:0] REPL_X1  = {24'hEFBFBD, 72'h0};
  localparam logic [95:0] REPL_X2  = {48'hEFBFBD_EFBFBD, 48'h0};

  // One input word plus, for hand-written rows, the output run it must cause.
  typedef struct packed {
    logic [7:0]       b;
    logic             fin;
    logic             typed;
    logic [3:0]       n;
    logic [0:11][7:0] e;
  } src_word_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       rl;
  } cesu_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u2c_in_if  in_if();
  u2c_out_if out_if();

  utf8_to_cesu8_transcoder_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  wire in_hs  = in_if.valid && in_if.ready;
  wire out_hs = out_if.valid && out_if.ready;

  src_word_t   send_q[$];       // words waiting for the sender
  src_word_t   cur_word;        // word currently offered on in_if
  cesu_word_t  cesu_q[$];       // CESU-8 words still owed by the block
  src_word_t   dir_tbl [26];
  int unsigned words_total;
  int unsigned words_in;
  logic        in_took;
  int unsigned errors;
  int unsigned idle_cycles;

  // ---------------------------------------------------------------------------
  // Decoder model: pending byte count, sequence length and gathered payload.
  // ---------------------------------------------------------------------------
  logic [1:0]       dec_pend;
  logic [2:0]       dec_len;
  logic [20:0]      dec_acc;
  logic [0:11][7:0] pred_bytes;
  int unsigned      pred_n;

  function void push_out(input logic [7:0] v);
    if (pred_n < 12) begin
      pred_bytes[pred_n] = v;
      pred_n++;
    end
  endfunction

  function void push_out3(input logic [15:0] u);
    push_out({4'hE, u[15:12]});
    push_out({2'b10, u[11:6]});
    push_out({2'b10, u[5:0]});
  endfunction

  // Re-encode one scalar; supplementary planes leave as two 3-byte surrogate halves.
  function void emit_code(input logic [20:0] cp);
    logic [19:0] v;
    v = 20'(cp - u2c_pkg::SUPP_BASE);
    if (cp < 21'h80) begin
      push_out(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_out({3'b110, cp[10:6]});
      push_out({2'b10, cp[5:0]});
    end else if (cp < u2c_pkg::SUPP_BASE) begin
      push_out3(cp[15:0]);
    end else begin
      push_out3(u2c_pkg::HI_SURR + {6'h00, v[19:10]});
      push_out3(u2c_pkg::LO_SURR + {6'h00, v[9:0] & u2c_pkg::LO_MASK});
    end
  endfunction

  // Replace every pending byte by U+FFFD and go idle.
  function void drop_pending();
    for (int i = 0; i < dec_pend; i++) push_out3(16'(u2c_pkg::REPL_CP));
    dec_pend = '0;
    dec_len  = '0;
    dec_acc  = '0;
  endfunction

  // Advance the decoder by one input byte; leaves the output run in pred_bytes/pred_n.
  function void transcode_byte(input logic [7:0] b, input logic fin);
    logic        ok;
    logic        taken;
    int unsigned nxt;
    pred_n = 0;
    taken  = 1'b0;
    if (dec_pend != 0) begin
      ok = (b[7:6] == 2'b10);
      // Second byte of a lead that limits its range: overlong, surrogate, above U+10FFFF.
      if (ok && dec_pend == 2'd1) begin
        if (dec_len == 3'd3) begin
          if (dec_acc == 21'h0 && b < 8'hA0) ok = 1'b0;
          if (dec_acc == 21'hD && b >= 8'hA0) ok = 1'b0;
        end else if (dec_len == 3'd4) begin
          if (dec_acc == 21'h0 && b < 8'h90) ok = 1'b0;
          if (dec_acc == 21'h4 && b >= 8'h90) ok = 1'b0;
        end
      end
      if (ok) begin
        dec_acc = {dec_acc[14:0], b[5:0]};
        nxt     = dec_pend + 1;
        if (nxt >= dec_len) begin
          emit_code(dec_acc);
          dec_pend = '0;
          dec_len  = '0;
          dec_acc  = '0;
        end else begin
          dec_pend = 2'(nxt);
        end
        taken = 1'b1;
      end else begin
        drop_pending();
      end
    end
    // A byte not absorbed by a sequence starts over, the failing byte included.
    if (!taken) begin
      if (b < 8'h80) begin
        push_out(b);
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        dec_len = 3'd2; dec_pend = 2'd1; dec_acc = {16'h0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        dec_len = 3'd3; dec_pend = 2'd1; dec_acc = {17'h0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        dec_len = 3'd4; dec_pend = 2'd1; dec_acc = {18'h0, b[2:0]};
      end else begin
        push_out3(16'(u2c_pkg::REPL_CP));
      end
    end
    // Flush a truncated sequence at the end of the buffer.
    if (fin && dec_pend != 0) drop_pending();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int utf8_encode(input logic [20:0] cp, output logic [0:3][7:0] bs);
    bs = '0;
    if (cp < 21'h80) begin
      bs[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      bs[0] = {3'b110, cp[10:6]};
      bs[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      bs[0] = {4'b1110, cp[15:12]};
      bs[1] = {2'b10, cp[11:6]};
      bs[2] = {2'b10, cp[5:0]};
      return 3;
    end
    bs[0] = {5'b11110, cp[20:18]};
    bs[1] = {2'b10, cp[17:12]};
    bs[2] = {2'b10, cp[11:6]};
    bs[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  // Pick a valid scalar value from a random encoding length class.
  function automatic logic [20:0] rand_scalar();
    logic [20:0] cp;
    case ($urandom_range(0, 3))
      0:       cp = 21'($urandom_range(0, 'h7F));
      1:       cp = 21'($urandom_range('h80, 'h7FF));
      2:       cp = 21'($urandom_range('h800, 'hFFFF));
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    // Move surrogate code units into the scalar range.
    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
    return cp;
  endfunction

  task automatic queue_word(input logic [7:0] b, input logic fin);
    send_q.push_back('{b: b, fin: fin, typed: 1'b0, n: 4'd0, e: NO_BYTES});
    words_total++;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch on %s: got %02h, want %02h", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Checker: retire output words first, then record what the accepted input owes.
  // Both in one process so the expectation store never sees a same-edge race.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    cesu_word_t want;
    if (!rst_ni) begin
      dec_pend = '0;
      dec_len  = '0;
      dec_acc  = '0;
      in_took  <= 1'b0;
      words_in <= 0;
    end else begin
      if (out_hs) begin
        if (cesu_q.size() == 0) begin
          report_mismatch("word with none expected", out_if.out_byte, 8'h00);
        end else begin
          want = cesu_q.pop_front();
          if (out_if.out_byte !== want.ob) report_mismatch("out_byte", out_if.out_byte, want.ob);
          if (out_if.run_last !== want.rl) begin
            report_mismatch("run_last", {7'h0, out_if.run_last}, {7'h0, want.rl});
          end
        end
      end
      in_took <= in_hs;
      if (in_hs) begin
        transcode_byte(in_if.in_byte, in_if.buffer_end);
        // Hand-written rows override the model run; the decoder state still advances.
        if (cur_word.typed) begin
          pred_bytes = cur_word.e;
          pred_n     = cur_word.n;
        end
        for (int i = 0; i < pred_n; i++) begin
          cesu_q.push_back('{ob: pred_bytes[i], rl: (i == pred_n - 1)});
        end
        words_in <= words_in + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps; hold a word until taken.
  // ---------------------------------------------------------------------------
  initial begin
    src_word_t   w;
    int unsigned burst_left;
    int unsigned gap_left;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.buffer_end = 1'b0;
    cur_word         = '0;
    burst_left       = $urandom_range(1, 24);
    gap_left         = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!in_if.valid || in_took) begin
        if (gap_left != 0) begin
          in_if.valid = 1'b0;
          gap_left--;
        end else if (send_q.size() != 0) begin
          w                = send_q.pop_front();
          cur_word         = w;
          in_if.in_byte    = w.b;
          in_if.buffer_end = w.fin;
          in_if.valid      = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_if.valid = 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotate through stall patterns; once, stall long enough that the
  // command queue fills and the block drops in_if.ready.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          held;
    out_if.ready = 1'b0;
    rx_cycle     = 0;
    hold_left    = 0;
    held         = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!held && words_in >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        case ((rx_cycle / 40) % 4)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          2:       out_if.ready = (rx_cycle % 3 == 0);
          default: out_if.ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which no word moves on either side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if (in_hs || out_hs) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t ns: no word moved for %0d cycles, %0d words still owed",
             $time, STALL_LIMIT, cesu_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [20:0]     cp;
    logic [0:3][7:0] bs;
    logic [7:0]      lead;
    logic [7:0]      second;
    int              nb;
    int              cut;
    int unsigned     pick;
    bit              at_end;
    errors      = 0;
    words_total = 0;
    rst_ni      = 1'b0;

    // Directed rows: byte, buffer_end, hand-written?, run length, run bytes.
    dir_tbl = '{
      '{8'h00, 1'b0, 1'b1, 4'd1,  {8'h00, 88'h0}},  // lowest ASCII
      '{8'h7F, 1'b0, 1'b1, 4'd1,  {8'h7F, 88'h0}},  // highest ASCII
      '{8'h80, 1'b0, 1'b1, 4'd3,  REPL_X1},         // stray continuation
      '{8'hFF, 1'b0, 1'b1, 4'd3,  REPL_X1},         // never-valid byte
      '{8'hC1, 1'b0, 1'b1, 4'd3,  REPL_X1},         // overlong two-byte lead
      '{8'hF5, 1'b0, 1'b1, 4'd3,  REPL_X1},         // lead above U+10FFFF
      '{8'hE0, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // U+0800, lowest 3-byte
      '{8'hA0, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'h80, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hED, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // surrogate rejected after ED
      '{8'hA0, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hF0, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // overlong rejected after F0
      '{8'h8F, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hF4, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // too large rejected after F4
      '{8'h90, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hF4, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // U+10FFFF as surrogate pair
      '{8'h8F, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hBF, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hBF, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hF1, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // three pending, then bad byte
      '{8'h80, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'h80, 1'b0, 1'b0, 4'd0,  NO_BYTES},
      '{8'hFF, 1'b0, 1'b0, 4'd0,  NO_BYTES},        // longest run: four replacements
      '{8'hE2, 1'b0, 1'b1, 4'd0,  NO_BYTES},        // truncated at buffer end
      '{8'h82, 1'b1, 1'b1, 4'd6,  REPL_X2},
      '{8'hC3, 1'b1, 1'b1, 4'd3,  REPL_X1}          // lone lead at buffer end
    };
    foreach (dir_tbl[i]) begin
      send_q.push_back(dir_tbl[i]);
      words_total++;
    end

    // Random part: mostly well-formed sequences, mixed with truncation, lead-range
    // violations and raw noise.
    while (words_total < $size(dir_tbl) + RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        cp     = rand_scalar();
        nb     = utf8_encode(cp, bs);
        at_end = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < nb; k++) queue_word(bs[k], at_end && (k == nb - 1));
      end else if (pick < 75) begin
        // Cut a multibyte sequence short: at buffer end, or by a non-continuation.
        cp     = 21'($urandom_range('h80, 'h10FFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
        nb     = utf8_encode(cp, bs);
        cut    = $urandom_range(1, nb - 1);
        at_end = 1'($urandom_range(0, 1));
        for (int k = 0; k < cut; k++) queue_word(bs[k], at_end && (k == cut - 1));
        if (!at_end) begin
          queue_word($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                          : 8'($urandom_range('hC0, 'hFF)),
                     1'($urandom_range(0, 1)));
        end
      end else if (pick < 85) begin
        // Second byte outside the range its lead allows.
        case ($urandom_range(0, 3))
          0:       begin lead = 8'hE0; second = 8'($urandom_range('h80, 'h9F)); end
          1:       begin lead = 8'hED; second = 8'($urandom_range('hA0, 'hBF)); end
          2:       begin lead = 8'hF0; second = 8'($urandom_range('h80, 'h8F)); end
          default: begin lead = 8'hF4; second = 8'($urandom_range('h90, 'hBF)); end
        endcase
        queue_word(lead, 1'b0);
        queue_word(second, $urandom_range(0, 3) == 0);
      end else begin
        queue_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end

    // Release reset and let the sender and receiver run.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every input word to be taken and every owed word to drain.
    while (words_in != words_total || cesu_q.size() != 0) @(negedge clk_i);
    // Give a late extra word the chance to show up.
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/u2c_pkg.sv
rtl/u2c_chan_if.sv
rtl/u2c_front.sv
rtl/u2c_queue.sv
rtl/u2c_back.sv
rtl/utf8_to_cesu8_transcoder_core.sv
dv/utf8_to_cesu8_transcoder_core_test.sv
